### sv/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Item types, the initial chaining value and the SM3 helper functions.
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } t_out_item;

    typedef struct packed {
        logic [15:0][31:0] words;
        logic              fin;
    } t_blk;

    localparam logic [7:0][31:0] IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };
    localparam logic [31:0] T_LO     = 32'h79CC4519;
    localparam logic [31:0] T_HI     = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [5:0] m;
        m = 6'd32 - {1'b0, n};
        return (v << n) | (v >> m);
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

### sv/sm3_front.sv
// ----------------------------------------------------------------------------
// SM3 front end
// Packs message word bytes into 64-byte blocks one byte per cycle (a block's
// last byte waits on a full queue), appends padding and length, queues blocks.
// ----------------------------------------------------------------------------
module sm3_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  sm3_pkg::t_in_item i_item,
    output logic            o_blk_push,
    output sm3_pkg::t_blk   o_blk,
    input  logic            i_blk_full
);
    import sm3_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DATA = 2'd1;
    localparam logic [1:0] F_PAD  = 2'd2;
    localparam logic [1:0] F_LEN  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [31:0]       r_word;
    logic [2:0]        r_nb;
    logic              r_last;
    logic [1:0]        r_bidx;
    logic [5:0]        r_fill;
    logic [63:0]       r_bitlen, n_bitlen;
    logic [63:0]       r_len, n_len;
    logic              r_first;
    logic [2:0]        r_lcnt;
    logic [15:0][31:0] r_buf;

    logic        put;
    logic [7:0]  byte_val;
    logic [31:0] new_word;
    logic [4:0]  sh;
    logic [5:0]  fill_nx;
    logic [2:0]  nb_clamp;

    assign full     = (r_state != F_IDLE);
    assign nb_clamp = (i_item.valid_bytes > 3'd4) ? 3'd4 : i_item.valid_bytes;
    assign put      = (r_state != F_IDLE) && !((r_fill == 6'd63) && i_blk_full);
    assign fill_nx  = r_fill + 6'd1;
    assign sh       = 5'd24 - {r_fill[1:0], 3'b000};

    always_comb begin
        case (r_state)
            F_DATA:  byte_val = 8'(r_word >> (5'd24 - {r_bidx, 3'b000}));
            F_PAD:   byte_val = r_first ? PAD_BYTE : 8'h00;
            F_LEN:   byte_val = r_len[63:56];
            default: byte_val = 8'h00;
        endcase
        if (r_fill[1:0] == 2'd0) begin
            new_word = {byte_val, 24'h0};
        end else begin
            new_word = r_buf[r_fill[5:2]] | (32'(byte_val) << sh);
        end
    end

    always_comb begin
        o_blk       = '0;
        o_blk.words = r_buf;
        o_blk.words[r_fill[5:2]] = new_word;
        o_blk.fin   = (r_state == F_LEN) && (r_lcnt == 3'd7);
    end
    assign o_blk_push = put && (r_fill == 6'd63);

    always_comb begin
        n_state  = r_state;
        n_bitlen = r_bitlen;
        n_len    = r_len;
        case (r_state)
            F_IDLE: begin
                if (push) begin
                    if (nb_clamp != 3'd0) begin
                        n_state = F_DATA;
                    end else if (i_item.last) begin
                        n_state  = F_PAD;
                        n_len    = r_bitlen;
                        n_bitlen = '0;
                    end
                end
            end
            F_DATA: begin
                if (put) begin
                    n_bitlen = r_bitlen + 64'd8;
                    if ({1'b0, r_bidx} == r_nb - 3'd1) begin
                        if (r_last) begin
                            n_state  = F_PAD;
                            n_len    = n_bitlen;
                            n_bitlen = '0;
                        end else begin
                            n_state = F_IDLE;
                        end
                    end
                end
            end
            F_PAD: begin
                if (put && fill_nx == 6'd56) begin
                    n_state = F_LEN;
                end
            end
            F_LEN: begin
                if (put) begin
                    n_len = {r_len[55:0], 8'h00};
                    if (r_lcnt == 3'd7) begin
                        n_state = F_IDLE;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_bidx   <= '0;
            r_first  <= 1'b0;
            r_lcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_bitlen <= n_bitlen;
            if (r_state == F_IDLE && push) begin
                r_bidx  <= '0;
                r_first <= 1'b1;
                r_lcnt  <= '0;
            end
            if (put) begin
                r_fill <= fill_nx;
                if (r_state == F_DATA) r_bidx <= r_bidx + 2'd1;
                if (r_state == F_PAD) r_first <= 1'b0;
                if (r_state == F_LEN) r_lcnt <= r_lcnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        if (r_state == F_IDLE && push) begin
            r_word <= i_item.msg_word;
            r_nb   <= nb_clamp;
            r_last <= i_item.last;
        end
        if (put) begin
            r_buf[r_fill[5:2]] <= new_word;
        end
    end

    a_len_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_LEN && $past(r_state) != F_LEN) |-> (r_fill == 6'd56))
        else $error("length field not aligned");
    a_fin_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_blk_push && o_blk.fin) |=> (r_state == F_IDLE))
        else $error("final block without return to idle");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_blk_push |-> !i_blk_full)
        else $error("block pushed into full queue");

endmodule

### sv/sm3_bq.sv
// ----------------------------------------------------------------------------
// SM3 block queue
// Two-entry queue of packed blocks between the front and the compressor.
// ----------------------------------------------------------------------------
module sm3_bq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sm3_pkg::t_blk i_blk,
    output logic          o_full,
    input  logic          i_pop,
    output sm3_pkg::t_blk o_blk,
    output logic          o_empty
);
    import sm3_pkg::*;

    t_blk       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_blk   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_blk;
    end

endmodule

### sv/sm3_back.sv
// ----------------------------------------------------------------------------
// SM3 compressor
// One round per cycle over a block, feed-forward into the chaining value,
// then delivers the eight digest words after a final block.
// ----------------------------------------------------------------------------
module sm3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sm3_pkg::t_blk      i_blk,
    input  logic               i_blk_empty,
    output logic               o_blk_pop,
    output logic               empty,
    input  logic               pop,
    output sm3_pkg::t_out_item o_item
);
    import sm3_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RND  = 2'd1;
    localparam logic [1:0] B_FF   = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]        r_state;
    logic [5:0]        r_round;
    logic [2:0]        r_idx;
    logic              r_fin;
    logic [7:0][31:0]  r_cv;
    logic [7:0][31:0]  r_wr;
    logic [15:0][31:0] r_w;

    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

    assign o_blk_pop = (r_state == B_IDLE) && !i_blk_empty;
    assign empty     = (r_state != B_OUT);
    assign o_item.digest_word = r_cv[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.digest_last = (r_idx == 3'd7);

    always_comb begin
        tj  = (r_round < 6'd16) ? T_LO : T_HI;
        a12 = rotl(r_wr[0], 5'd12);
        ss1 = rotl(a12 + r_wr[4] + rotl(tj, r_round[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_round < 6'd16) begin
            ff = r_wr[0] ^ r_wr[1] ^ r_wr[2];
            gg = r_wr[4] ^ r_wr[5] ^ r_wr[6];
        end else begin
            ff = (r_wr[0] & r_wr[1]) | (r_wr[0] & r_wr[2]) | (r_wr[1] & r_wr[2]);
            gg = (r_wr[4] & r_wr[5]) | (~r_wr[4] & r_wr[6]);
        end
        tt1   = ff + r_wr[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2   = gg + r_wr[7] + ss1 + r_w[0];
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
              ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_cv    <= IV;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (o_blk_pop) begin
                        r_state <= B_RND;
                        r_round <= '0;
                    end
                end
                B_RND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= B_FF;
                end
                B_FF: begin
                    r_cv    <= r_cv ^ r_wr;
                    r_idx   <= '0;
                    r_state <= r_fin ? B_OUT : B_IDLE;
                end
                B_OUT: begin
                    if (pop) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_cv    <= IV;
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_blk_pop) begin
            r_w   <= i_blk.words;
            r_wr  <= r_cv;
            r_fin <= i_blk.fin;
        end else if (r_state == B_RND) begin
            r_w     <= {w_new, r_w[15:1]};
            r_wr[3] <= r_wr[2];
            r_wr[2] <= rotl(r_wr[1], 5'd9);
            r_wr[1] <= r_wr[0];
            r_wr[0] <= tt1;
            r_wr[7] <= r_wr[6];
            r_wr[6] <= rotl(r_wr[5], 5'd19);
            r_wr[5] <= r_wr[4];
            r_wr[4] <= perm0(tt2);
        end
    end

    a_ff_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FF) |-> $past(r_state == B_RND && r_round == 6'd63))
        else $error("feed-forward without full round count");
    a_out_from_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == B_OUT) |-> (r_idx == 3'd0))
        else $error("digest output not starting at word zero");
    a_iv_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && r_idx == 3'd7) |=> (r_cv == IV))
        else $error("chaining value not restored");

endmodule

### sv/sm3_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 hash: byte packing and padding front, two-block queue,
// one-round-per-cycle compressor with digest output.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  input    push / full         i_item (msg_word, valid_bytes, last)
//  result   empty / pop         o_item (digest_word, word_index, digest_last)
//
//  The front takes a word, then packs its valid bytes one byte per cycle
//  unless stalled, plus up to 72 bytes of padding and length on a last word.
//  The front, not the compressor, sets the sustained rate for full words.
//  A last word yields eight results; the compressor holds while they wait,
//  and the front stalls on the last byte of a block while the queue is full.
//  Reset is synchronous; the chaining value returns to the initial value.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sm3_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output sm3_pkg::t_out_item o_item
);
    import sm3_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_blk q_in, q_out;

    sm3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_blk_push (q_push),
        .o_blk      (q_in),
        .i_blk_full (q_full)
    );

    sm3_bq u_bq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_blk   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_blk   (q_out),
        .o_empty (q_empty)
    );

    sm3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (q_out),
        .i_blk_empty (q_empty),
        .o_blk_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

endmodule

### tb/sm3_hash_engine_checker.sv
// ----------------------------------------------------------------------------
// SM3 hash engine checker
// Watches both queue ports, predicts digests from accepted items with an
// independent SM3 model, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module sm3_hash_engine_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  sm3_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  sm3_pkg::t_out_item i_res,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sm3_pkg::*;

    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int          fill;
    logic [63:0] nbits;
    t_out_item   digest_q [$];

    function automatic logic [31:0] rl(logic [31:0] v, int n);
        n = n % 32;
        if (n == 0) return v;
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] p0f(logic [31:0] x);
        return x ^ rl(x, 9) ^ rl(x, 17);
    endfunction

    function automatic logic [31:0] p1f(logic [31:0] x);
        return x ^ rl(x, 15) ^ rl(x, 23);
    endfunction

    task automatic compress();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, ff, gg, tj;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1f(w[j-16] ^ w[j-9] ^ rl(w[j-3], 15)) ^ rl(w[j-13], 7) ^ w[j-6];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_LO : T_HI;
            ss1 = rl(rl(a, 12) + e + rl(tj, j), 7);
            ss2 = ss1 ^ rl(a, 12);
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rl(b, 9); b = a; a = tt1;
            h = g; g = rl(f, 19); f = e; e = p0f(tt2);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic add_byte(logic [7:0] v);
        int sh;
        sh = 24 - 8 * (fill % 4);
        if (fill % 4 == 0) blk[fill / 4] = 32'h0;
        blk[fill / 4] |= 32'(v) << sh;
        fill++;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
    endtask

    task automatic hash_item(t_in_item it);
        int          nb;
        logic [63:0] len;
        t_out_item   r;
        nb = (it.valid_bytes > 4) ? 4 : int'(it.valid_bytes);
        for (int i = 0; i < nb; i++) begin
            add_byte(it.msg_word[31 - 8*i -: 8]);
            nbits += 64'd8;
        end
        if (!it.last) return;
        len = nbits;
        add_byte(PAD_BYTE);
        while (fill != 56) add_byte(8'h00);
        for (int i = 0; i < 8; i++) add_byte(len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            r.digest_word = chain[i];
            r.word_index  = 3'(i);
            r.digest_last = (i == 7);
            digest_q.push_back(r);
            chain[i] = IV[i];
        end
        nbits = '0;
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) chain[i] = IV[i];
            fill = 0;
            nbits = '0;
            digest_q.delete();
            o_errors <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = digest_q.pop_front();
                    if (exp_r.digest_word !== i_res.digest_word ||
                        exp_r.word_index !== i_res.word_index ||
                        exp_r.digest_last !== i_res.digest_last) begin
                        $display("%0t: result error, expected %h/%0d/%0b, actual %h/%0d/%0b",
                                 $time, exp_r.digest_word, exp_r.word_index,
                                 exp_r.digest_last, i_res.digest_word,
                                 i_res.word_index, i_res.digest_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_push && !i_full) hash_item(i_item);
        end
        o_pending <= digest_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

### tb/tb_sm3_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Drives directed and random messages through the input queue with random
// gaps and result stalls; the checker compares every digest word.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sm3_pkg::*;

    localparam int LIMIT = 1500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    t_in_item           i_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    t_out_item          o_item;
    int                 errors, pending;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_off = 1'b0;

    always #6 i_clk = ~i_clk;

    sm3_hash_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_item(i_item), .empty(empty), .pop(pop), .o_item(o_item)
    );

    sm3_hash_engine_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_item(i_item), .i_empty(empty), .i_pop(pop), .i_res(o_item),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("sm3_hash_engine_unit: mismatch");
            $finish;
        end
    end

    // result side: random stall bursts, long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [31:0] w, logic [2:0] nb, logic fin);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{msg_word: w, valid_bytes: nb, last: fin};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_message(int nwords);
        for (int i = 0; i < nwords; i++)
            send($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial begin
        int sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, field extremes, padding boundaries
        send(32'h0, 3'd0, 1'b1);
        send(32'h61626300, 3'd3, 1'b1);
        send(32'hFFFFFFFF, 3'd7, 1'b0);
        send(32'hFFFFFFFF, 3'd5, 1'b0);
        send(32'h12345678, 3'd0, 1'b0);
        send(32'hA5A5A5A5, 3'd6, 1'b1);
        for (int i = 0; i < 13; i++) send(32'h61626364, 3'd4, 1'b0);
        send(32'h61626364, 3'd4, 1'b1);
        send(32'hDEADBEEF, 3'd1, 1'b1);
        send(32'h0, 3'd4, 1'b0);
        send(32'h0, 3'd0, 1'b1);
        sent = 23;
        push <= 1'b0;
        @(posedge i_clk iff pending == 0);
        // fill the block queue while the result side holds off
        hold_off = 1'b1;
        for (int m = 0; m < 4; m++) begin
            int k;
            k = $urandom_range(0, 3);
            send_message(k);
            sent += k + 1;
        end
        while (sent < 120) begin
            int k;
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 8);
            send_message(k);
            sent += k + 1;
        end
        calm = 1'b1;
        while (sent < 180) begin
            int k;
            k = $urandom_range(0, 6);
            send_message(k);
            sent += k + 1;
        end
        push <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("sm3_hash_engine_unit: match");
        end else begin
            $display("sm3_hash_engine_unit: mismatch");
        end
        $finish;
    end
endmodule

### filelist.f
sv/sm3_pkg.sv
sv/sm3_front.sv
sv/sm3_bq.sv
sv/sm3_back.sv
sv/sm3_hash_engine_unit.sv
tb/sm3_hash_engine_checker.sv
tb/tb_sm3_hash_engine_unit.sv
